// ----- hw/rtl/smsr_pkg.sv -----
package smsr_pkg;

    localparam int MaxSamples = 256;
    localparam int AddrW = $clog2(MaxSamples);
    localparam int CntW = AddrW + 1;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StSingle  = 2'd1;
    localparam logic [1:0] StZero    = 2'd2;
    localparam logic [1:0] StDropped = 2'd3;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] mean;
        logic [31:0]        std_dev;
        logic signed [31:0] rsd_percent;
        logic [8:0]         sample_count;
        logic [1:0]         status;
    } t_out_beat;

    typedef struct packed {
        logic              start;
        logic              is_signed;
        logic [127:0]      dividend;
        logic [63:0]       divisor;
    } t_div_req;

endpackage

// ----- hw/rtl/smsr_divider.sv -----
module smsr_divider
    import smsr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_div_req     i_req,
    output logic         o_done,
    output logic [127:0] o_quot
);

    logic [127:0] r_q, n_q;
    logic [63:0]  r_rem, n_rem;
    logic [63:0]  r_div;
    logic [7:0]   r_cnt;
    logic         r_busy, r_neg, r_done;
    logic [64:0]  w_trial;
    logic [64:0]  w_shift;

    assign w_shift = {r_rem, r_q[127]};
    assign w_trial = w_shift - {1'b0, r_div};

    always_comb begin
        if (!w_trial[64]) begin
            n_rem = w_trial[63:0];
            n_q   = {r_q[126:0], 1'b1};
        end else begin
            n_rem = w_shift[63:0];
            n_q   = {r_q[126:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            if (i_req.is_signed) begin
                r_neg <= i_req.dividend[127] ^ i_req.divisor[63];
                r_q   <= i_req.dividend[127] ? -i_req.dividend : i_req.dividend;
                r_div <= i_req.divisor[63] ? -i_req.divisor : i_req.divisor;
            end else begin
                r_neg <= 1'b0;
                r_q   <= i_req.dividend;
                r_div <= i_req.divisor;
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_q : r_q;

endmodule

// ----- hw/rtl/smsr_sqrt.sv -----
module smsr_sqrt
    import smsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_x, r_res, r_bit;
    logic        r_busy, r_done;
    logic [63:0] w_sum;

    assign w_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_x >= w_sum) begin
                r_x   <= r_x - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ----- hw/rtl/sample_mean_stddev_rsd.sv -----
// Sequence: a last sample starts the mean division, then a sweep over the stored
// samples, the variance division, a 32-step root and the RSD division (all three
// divisions are 128-step divisions); a single sample skips the variance division and
// root, and a zero mean skips the last division.
// Throughput: one sample per cycle while loading; one set at a time during the pass.
// Reset: synchronous active low; clears count, sum, drop flag and the sequencer.
// The sample memory has no reset; only entries written in the current set are read.
module sample_mean_stddev_rsd
    import smsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    localparam logic [2:0] SLoad = 3'd0;
    localparam logic [2:0] SMean = 3'd1;
    localparam logic [2:0] SSweep = 3'd2;
    localparam logic [2:0] SVar = 3'd3;
    localparam logic [2:0] SRoot = 3'd4;
    localparam logic [2:0] SRsd = 3'd5;
    localparam logic [2:0] SOut = 3'd6;

    logic signed [31:0] mem [MaxSamples];
    logic signed [31:0] r_rd;
    logic [2:0]   r_st;
    logic [CntW-1:0] r_cnt, r_idx;
    logic signed [39:0] r_sum;
    logic         r_ovf, r_rdv, r_wait;
    logic signed [63:0] r_mean;
    logic [63:0]  r_sq;
    logic [127:0] r_acc;
    logic [31:0]  r_sd;
    logic         w_acc, w_full;
    t_div_req     w_req;
    logic         w_ddone, w_sdone, w_sstart;
    logic [127:0] w_q;
    logic [31:0]  w_root;
    logic signed [32:0] w_dev;
    logic [32:0]  w_mag;
    t_out_beat    r_out;

    assign w_full = (r_cnt == CntW'(MaxSamples));
    assign o_stall = (r_st != SLoad);
    assign w_acc = i_valid && (r_st == SLoad);
    assign w_dev = 33'(r_rd) - r_mean[32:0];
    assign w_mag = w_dev[32] ? -w_dev : w_dev;

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_full) begin
            mem[r_cnt[AddrW-1:0]] <= i_data.sample;
        end
        r_rd <= mem[r_idx[AddrW-1:0]];
    end

    always_comb begin
        w_req = '0;
        w_sstart = 1'b0;
        if (r_st == SLoad && w_acc && i_data.last) begin
            w_req.start = 1'b1;
            w_req.is_signed = 1'b1;
            w_req.dividend = 128'(signed'(w_full ? r_sum : r_sum + 40'(i_data.sample)));
            w_req.divisor = 64'(w_full ? r_cnt : r_cnt + CntW'(1));
        end else if (r_st == SVar && !r_wait) begin
            w_req.start = (r_cnt > CntW'(1));
            w_req.dividend = r_acc;
            w_req.divisor = 64'(r_cnt - CntW'(1));
        end else if (r_st == SRsd && !r_wait) begin
            w_req.start = (r_mean != 0);
            w_req.is_signed = 1'b1;
            w_req.dividend = 128'({32'd0, r_sd} * 64'd100) << 16;
            w_req.divisor = r_mean;
        end
        if (r_st == SRoot && !r_wait) begin
            w_sstart = 1'b1;
        end
    end

    smsr_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_ddone),
        .o_quot (w_q)
    );

    smsr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sstart),
        .i_x    (r_sq),
        .o_done (w_sdone),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SLoad;
            r_cnt <= '0;
            r_sum <= '0;
            r_ovf <= 1'b0;
            r_wait <= 1'b0;
            r_rdv <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            case (r_st)
                SLoad: begin
                    if (w_acc) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt <= r_cnt + CntW'(1);
                            r_sum <= r_sum + 40'(i_data.sample);
                        end
                        if (i_data.last) begin
                            r_st <= SMean;
                        end
                    end
                end
                SMean: begin
                    if (w_ddone) begin
                        r_mean <= signed'(w_q[63:0]);
                        r_idx <= '0;
                        r_acc <= '0;
                        r_rdv <= 1'b0;
                        r_st <= SSweep;
                    end
                end
                SSweep: begin
                    r_rdv <= (r_idx < r_cnt);
                    if (r_idx < r_cnt) begin
                        r_idx <= r_idx + CntW'(1);
                    end
                    if (r_rdv) begin
                        r_acc <= r_acc + 128'(64'(w_mag) * 64'(w_mag));
                    end
                    if (!r_rdv && r_idx == r_cnt && r_idx != '0) begin
                        r_wait <= 1'b0;
                        r_st <= SVar;
                    end
                end
                SVar: begin
                    if (!r_wait) begin
                        if (r_cnt > CntW'(1)) begin
                            r_wait <= 1'b1;
                        end else begin
                            r_sd <= '0;
                            r_st <= SRsd;
                        end
                    end else if (w_ddone) begin
                        r_sq <= (w_q[127:64] != '0) ? '1 : w_q[63:0];
                        r_wait <= 1'b0;
                        r_st <= SRoot;
                    end
                end
                SRoot: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_sdone) begin
                        r_sd <= w_root;
                        r_wait <= 1'b0;
                        r_st <= SRsd;
                    end
                end
                SRsd: begin
                    r_out.mean <= r_mean[31:0];
                    r_out.std_dev <= r_sd;
                    r_out.sample_count <= 9'(r_cnt);
                    r_out.status <= r_ovf ? StDropped :
                                    (r_cnt == CntW'(1)) ? StSingle :
                                    (r_mean == 0) ? StZero : StOk;
                    if (!r_wait) begin
                        if (r_mean != 0) begin
                            r_wait <= 1'b1;
                        end else begin
                            r_out.rsd_percent <= '0;
                            r_st <= SOut;
                            o_valid <= 1'b1;
                        end
                    end else if (w_ddone) begin
                        if (!w_q[127] && w_q[126:31] != '0) begin
                            r_out.rsd_percent <= 32'h7FFF_FFFF;
                        end else if (w_q[127] && w_q[126:31] != '1) begin
                            r_out.rsd_percent <= 32'h8000_0000;
                        end else begin
                            r_out.rsd_percent <= w_q[31:0];
                        end
                        r_wait <= 1'b0;
                        r_st <= SOut;
                        o_valid <= 1'b1;
                    end
                end
                SOut: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_cnt <= '0;
                        r_sum <= '0;
                        r_ovf <= 1'b0;
                        r_st <= SLoad;
                    end
                end
                default: r_st <= SLoad;
            endcase
        end
    end

    assign o_data = r_out;

endmodule

// ----- bench/tb_sample_mean_stddev_rsd.sv -----
module tb_sample_mean_stddev_rsd;
    import smsr_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_data;

    sample_mean_stddev_rsd dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    localparam int CycleLimit = 5000000;

    t_in_beat  pending_samples[$];
    t_out_beat expected_stats[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    logic signed [31:0] set_store[MaxSamples];
    int unsigned        set_count = 0;
    longint             set_sum = 0;
    bit                 set_dropped = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void accumulate_sample(input t_in_beat b);
        longint       mn;
        longint       d;
        longint       num;
        longint       rsd;
        logic [63:0]  m;
        logic [63:0]  sd;
        logic [127:0] acc;
        logic [127:0] qw;
        t_out_beat    r;
        if (set_count < MaxSamples) begin
            set_store[set_count] = b.sample;
            set_sum += longint'(b.sample);
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!b.last) return;
        mn = set_sum / longint'(set_count);
        acc = '0;
        for (int i = 0; i < set_count; i++) begin
            d = longint'(set_store[i]) - mn;
            m = (d < 0) ? 64'(-d) : 64'(d);
            acc = acc + ({64'd0, m} * {64'd0, m});
        end
        if (set_count > 1) begin
            qw = acc / 128'(set_count - 1);
            sd = floor_root((qw[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : qw[63:0]);
            if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
        end else begin
            sd = '0;
        end
        if (mn != 0) begin
            num = longint'((sd * 64'd100) << 16);
            rsd = num / mn;
            if (rsd > 64'sd2147483647) rsd = 64'sd2147483647;
            if (rsd < -64'sd2147483648) rsd = -64'sd2147483648;
        end else begin
            rsd = 0;
        end
        r.mean = mn[31:0];
        r.std_dev = sd[31:0];
        r.rsd_percent = rsd[31:0];
        r.sample_count = 9'(set_count);
        if (set_dropped) r.status = StDropped;
        else if (set_count == 1) r.status = StSingle;
        else if (mn == 0) r.status = StZero;
        else r.status = StOk;
        expected_stats.push_back(r);
        set_count = 0;
        set_sum = 0;
        set_dropped = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                accumulate_sample(i_data);
                void'(pending_samples.pop_front());
            end
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data <= pending_samples[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, o_data);
                error_count++;
            end else begin
                exp_r = expected_stats.pop_front();
                report_field("mean", exp_r.mean, o_data.mean);
                report_field("std_dev", exp_r.std_dev, o_data.std_dev);
                report_field("rsd_percent", exp_r.rsd_percent, o_data.rsd_percent);
                report_field("sample_count", 32'(exp_r.sample_count), 32'(o_data.sample_count));
                report_field("status", 32'(exp_r.status), 32'(o_data.status));
            end
        end
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= 800;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("tb_sample_mean_stddev_rsd NOT OK");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_sample(input int mode, input int base);
        case (mode)
            0: return $urandom;
            1: return base + $signed($urandom_range(8192)) - 4096;
            default: begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic queue_set(input int len, input int mode);
        t_in_beat b;
        int base;
        base = $signed($urandom) >>> ($urandom_range(1) ? 1 : 12);
        for (int i = 0; i < len; i++) begin
            b.sample = pick_sample(mode, base);
            b.last = (i == len - 1);
            pending_samples.push_back(b);
        end
    endtask

    task automatic queue_fixed(input logic signed [31:0] vals[$]);
        t_in_beat b;
        foreach (vals[i]) begin
            b.sample = vals[i];
            b.last = (i == vals.size() - 1);
            pending_samples.push_back(b);
        end
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || i_valid || expected_stats.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int items, input bit with_overflow);
        int queued;
        int overflow_at;
        queued = 0;
        overflow_at = $urandom_range(items / 2);
        while (queued < items) begin
            int len;
            if (with_overflow && queued >= overflow_at) begin
                len = $urandom_range(257, 266);
                with_overflow = 1'b0;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
            end
            queue_set(len, ($urandom_range(9) < 5) ? 1 : ($urandom_range(3) == 0 ? 2 : 0));
            queued += len;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_fixed('{32'sd0});
        queue_fixed('{32'sh7FFF_FFFF});
        queue_fixed('{32'sh8000_0000, 32'sh8000_0000});
        queue_fixed('{32'sh7FFF_FFFF, 32'sh8000_0000});
        queue_fixed('{32'sd5 <<< 16, 32'sd7 <<< 16, 32'sd9 <<< 16});
        queue_fixed('{-(32'sd3 <<< 16), -(32'sd5 <<< 16)});
        queue_fixed('{32'sd1, -32'sd1, 32'sd1, -32'sd1});
        queue_fixed('{32'sh4000_0000, -32'sh3FFF_FFFE});
        queue_fixed('{-32'sh4000_0000, 32'sh3FFF_FFFE});
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1) ? 69 : (p == 3) ? 31 : 0;
            recv_stall_pct = (p == 2) ? 69 : (p == 3) ? 31 : 0;
            queue_random(260, (p == 1 || p == 3));
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = hold_requests + 1;
        queue_random(60, 1'b0);
        drain();

        while (expected_stats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (600) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_sample_mean_stddev_rsd OK");
        end else begin
            $display("tb_sample_mean_stddev_rsd NOT OK");
        end
        $finish;
    end

endmodule
